// ----- rtl/svsm_pkg.sv -----
// shared types and constants for the smoothed vca stereo mixer
// no dependencies; imported by svsm_gain, svsm_lane and the top level
`timescale 1ns / 1ps

package svsm_pkg;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned OUT_W        = 24;
  localparam int unsigned GAIN_OUT_W   = 17;
  localparam int unsigned COEFF_W      = 16;
  localparam int unsigned DUTY_W       = 8;
  localparam int unsigned REVERB_SHARE = 44564;
  localparam int unsigned SAMPLE_MAX   = 32767;
  localparam int unsigned SAMPLE_NEG   = 32768;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd249;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_UPD,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic update;
    logic mult;
  } ctrl_t;

endpackage

// ----- rtl/svsm_gain.sv -----
// one-pole gain smoother: target lookup, step product and gain update
// depends on svsm_pkg
`timescale 1ns / 1ps

module svsm_gain #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  svsm_pkg::ctrl_t               ctrl,
  input  logic [svsm_pkg::DUTY_W-1:0]   duty,
  input  logic [svsm_pkg::COEFF_W-1:0]  coeff,
  output logic [GAIN_FRAC_BITS:0]       gain
);
  import svsm_pkg::*;

  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam int PW = GW + COEFF_W;

  function automatic logic [255:0][GW-1:0] build_tgt();
    logic [255:0][GW-1:0] t;
    logic [39:0] x;
    for (int i = 0; i < 256; i++) begin
      x = (40'(255 - i) << GAIN_FRAC_BITS) + 40'd127;
      t[i] = GW'(x / 40'd255);
    end
    return t;
  endfunction

  localparam logic [255:0][GW-1:0] TGT_LUT = build_tgt();

  logic [GW-1:0] target;
  logic          up;
  logic [PW-1:0] prod;
  logic [GW-1:0] diff;
  logic [PW:0]   rounded;
  logic [GW-1:0] step_amt;

  assign diff     = (target >= gain) ? (target - gain) : (gain - target);
  assign rounded  = {1'b0, prod} + (PW+1)'(32768);
  assign step_amt = rounded[GW+15:16];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      target <= TGT_LUT[duty];
    end
    if (ctrl.step) begin
      up   <= (target >= gain);
      prod <= PW'(diff) * PW'(coeff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
    end else if (ctrl.update) begin
      gain <= up ? (gain + step_amt) : (gain - step_amt);
    end
  end

endmodule

// ----- rtl/svsm_lane.sv -----
// one side of the mixer: dry and reverb mix, gain multiply, saturation
// depends on svsm_pkg
`timescale 1ns / 1ps

module svsm_lane #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  svsm_pkg::ctrl_t                     ctrl,
  input  logic signed [svsm_pkg::SAMPLE_W-1:0] dry_a,
  input  logic signed [svsm_pkg::SAMPLE_W-1:0] dry_b,
  input  logic signed [svsm_pkg::SAMPLE_W-1:0] wet,
  input  logic [GAIN_FRAC_BITS:0]             gain,
  output logic signed [svsm_pkg::OUT_W-1:0]   result
);
  import svsm_pkg::*;

  localparam int GW  = GAIN_FRAC_BITS + 1;
  localparam int ABW = 17 + GW + 1;
  localparam int WMW = 33;
  localparam int PWW = WMW + GW + 1;
  localparam int PW  = GW + 35;
  localparam int SH  = 16 + GAIN_FRAC_BITS;
  localparam int QW  = PW - SH;
  localparam logic signed [16:0] SHARE = 17'(REVERB_SHARE);

  logic signed [16:0]    sum_ab;
  logic signed [WMW-1:0] wm;
  logic signed [ABW-1:0] pab;
  logic signed [PWW-1:0] pw;
  logic signed [GW:0]    gain_s;
  logic signed [PW-1:0]  p;
  logic                  neg;
  logic [PW-1:0]         mag;
  logic [QW-1:0]         q;
  logic signed [15:0]    sat;

  assign gain_s = $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sum_ab <= 17'(dry_a) + 17'(dry_b);
      wm     <= wet * SHARE;
    end
    if (ctrl.mult) begin
      pab <= sum_ab * gain_s;
      pw  <= wm * gain_s;
    end
  end

  always_comb begin
    p   = (PW'(pab) <<< 16) + PW'(pw);
    neg = p[PW-1];
    mag = neg ? PW'(-p) : PW'(p);
    q   = mag[PW-1:SH];
    if (neg) begin
      sat = (q > QW'(SAMPLE_NEG)) ? -16'sd32768 : 16'(-q);
    end else begin
      sat = (q > QW'(SAMPLE_MAX)) ? 16'sd32767 : 16'(q);
    end
    result = {sat, 8'h00};
  end

endmodule

// ----- rtl/smoothed_vca_stereo_mixer.sv -----
// an accepted item passes the step, update and multiply states and the merge before its result is shown
// a new item is taken only after the last one has gone through the sequence
//   target lookup, step multiply, gain update, lane multiply, merge (held while the output is not taken)
// reset: gain cleared to zero (fade up from silence), coefficient 249, output empty
// top level; depends on svsm_pkg, svsm_gain and svsm_lane
`timescale 1ns / 1ps

module smoothed_vca_stereo_mixer #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // atten_duty[7:0], dry_a_left, dry_b_left, wet_left, dry_a_right, dry_b_right, wet_right
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_left[23:0], out_right[47:24], gain_now[64:48], zero pad
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);
  import svsm_pkg::*;

  localparam int GW = GAIN_FRAC_BITS + 1;

  state_t state, state_next;
  ctrl_t  ctrl;
  logic   out_load;

  logic [COEFF_W-1:0]          coeff;
  logic [GW-1:0]               gain;
  logic signed [OUT_W-1:0]     res_left;
  logic signed [OUT_W-1:0]     res_right;
  logic [GAIN_OUT_W-1:0]       gain_q16;
  logic [OUT_W-1:0]            out_left;
  logic [OUT_W-1:0]            out_right;
  logic [GAIN_OUT_W-1:0]       gain_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= COEFF_RESET;
    end else if (cfg_wr_en) begin
      coeff <= cfg_wr_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_STEP;
      ST_STEP: state_next = ST_UPD;
      ST_UPD:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ctrl          = '0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = !rst;
        ctrl.load     = s_axis_tvalid && !rst;
      end
      ST_STEP: ctrl.step = 1'b1;
      ST_UPD:  ctrl.update = 1'b1;
      ST_MUL:  ctrl.mult = 1'b1;
      ST_OUT:  out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  svsm_gain #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_gain (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .duty  (s_axis_tdata[7:0]),
    .coeff (coeff),
    .gain  (gain)
  );

  svsm_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_left (
    .clk    (clk),
    .ctrl   (ctrl),
    .dry_a  (s_axis_tdata[23:8]),
    .dry_b  (s_axis_tdata[39:24]),
    .wet    (s_axis_tdata[55:40]),
    .gain   (gain),
    .result (res_left)
  );

  svsm_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_right (
    .clk    (clk),
    .ctrl   (ctrl),
    .dry_a  (s_axis_tdata[71:56]),
    .dry_b  (s_axis_tdata[87:72]),
    .wet    (s_axis_tdata[103:88]),
    .gain   (gain),
    .result (res_right)
  );

  generate
    if (GAIN_FRAC_BITS >= 16) begin : g_gain_trunc
      assign gain_q16 = gain[GAIN_FRAC_BITS:GAIN_FRAC_BITS-16];
    end else begin : g_gain_pad
      assign gain_q16 = {gain, {(16-GAIN_FRAC_BITS){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left  <= res_left;
      out_right <= res_right;
      gain_now  <= gain_q16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {7'b0, gain_now, out_right, out_left};

  a_valid_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_OUT))
    else $error("result shown without a merge");

  a_accept_starts_step: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_STEP))
    else $error("accepted item did not start the gain step");

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    gain <= (GW'(1) << GAIN_FRAC_BITS))
    else $error("smoothed gain above unity");

  a_out_scaled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_left[7:0] == 8'h00 && out_right[7:0] == 8'h00))
    else $error("side output not a multiple of 256");

endmodule
